@@ rtl/sct_pkg.sv @@
// Shared constants, register and surface codes, and sequencer states of the sector timer.
`default_nettype none

package sct_pkg;

   // Fixed-point format and field widths
   localparam int FRACTION_BITS = 16;
   localparam int MAX_SECTORS   = 4;
   localparam int POS_W         = 16;
   localparam int TICK_W        = 32;
   localparam int TIME_W        = 48;
   localparam int SECTOR_W      = 2;
   localparam int COUNT_W       = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   // Derived datapath widths
   localparam int PREV_W      = POS_W + 2;
   localparam int NUM_W       = POS_W + 3;
   localparam int DEN_W       = POS_W + 1;
   localparam int QUO_W       = DEN_W + FRACTION_BITS;
   localparam int QUO_LO_W    = DEN_W;
   localparam int QUO_HI_W    = QUO_W - QUO_LO_W;
   localparam int DMAG_W      = TICK_W + 1;
   localparam int DELTA_W     = TICK_W + 2;
   localparam int MUL_W       = DMAG_W + QUO_LO_W;
   localparam int MAGSUM_W    = MUL_W + QUO_LO_W + 1;
   localparam int MAG_W       = 63;
   localparam int SUM_W       = MAG_W + 2;
   localparam int DIV_CNT_W   = $clog2(QUO_W);
   localparam int ONE_FX      = 1 << FRACTION_BITS;

   localparam logic [MAG_W-1:0] PROD_LIMIT = MAG_W'(1) << (MAG_W - 1);

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_0   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_1   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_2   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_3   = 3'd4;

   // Surface codes; anything unlisted counts as off track
   localparam logic [2:0] SURF_NOT_IN_WORLD = 3'd0;
   localparam logic [2:0] SURF_OFF_TRACK    = 3'd1;
   localparam logic [2:0] SURF_PIT_STALL    = 3'd2;
   localparam logic [2:0] SURF_PIT_APPROACH = 3'd3;
   localparam logic [2:0] SURF_ON_TRACK     = 3'd4;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EVAL   = 7'b0000010,
      ST_DIVIDE = 7'b0000100,
      ST_MUL_LO = 7'b0001000,
      ST_MUL_HI = 7'b0010000,
      ST_SAT    = 7'b0100000,
      ST_SUM    = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/sector_crossing_timer_unit.sv @@
// Sector crossing timer: sector search, serial divide and shared multiplier for crossing time.
// Steps: an item with no sector change is done after acceptance with one evaluation step.
// An item with a sector change shows its transaction after acceptance: 33 divide steps
// in the restoring divider, two passes of one 33x17 multiplier, saturate, sum; a zero divisor
// skips the divider. The sum waits for a free output; new items are taken only in idle.
// Reset: synchronous, active high; no sector, position and tick -1, pit flags clear, registers
// at their reset values; no clearing pass.
`default_nettype none

module sector_crossing_timer_unit
   import sct_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [TICK_W-1:0]            req_tick,
   input  wire  [POS_W-1:0]             req_lap_position,
   input  wire  [2:0]                   req_surface,

   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [TIME_W-1:0]            rsp_crossing_time,
   output logic signed [2:0]            rsp_from_sector,
   output logic [SECTOR_W-1:0]          rsp_to_sector,
   output logic                         rsp_crossed_line,
   output logic                         rsp_lap_pitted,

   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [CSR_INDEX_W-1:0]       csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_data
);

   // Control state
   state_type                  state_ff, state_in;
   logic [COUNT_W-1:0]         sector_count_ff, sector_count_in;
   logic [POS_W-1:0]           boundary_ff [MAX_SECTORS];
   logic [POS_W-1:0]           boundary_in [MAX_SECTORS];
   logic signed [2:0]          cur_sector_ff, cur_sector_in;
   logic signed [PREV_W-1:0]   last_pos_ff, last_pos_in;
   logic signed [TICK_W:0]     last_tick_ff, last_tick_in;
   logic                       pitted_ff, pitted_in;
   logic                       suppress_ff, suppress_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [TICK_W-1:0]          tick_ff, tick_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [2:0]                 surface_ff, surface_in;
   logic [DMAG_W-1:0]          dmag_ff, dmag_in;
   logic signed [TICK_W:0]     base_ff, base_in;
   logic                       neg_ff, neg_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [QUO_W-1:0]           qd_ff, qd_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [MUL_W-1:0]           plo_ff, plo_in;
   logic [MUL_W-1:0]           phi_ff, phi_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [TIME_W-1:0]          time_ff, time_in;
   logic [SECTOR_W-1:0]        new_sector_ff, new_sector_in;
   logic signed [2:0]          old_sector_ff, old_sector_in;
   logic                       line_ff, line_in;
   logic                       lap_pitted_ff, lap_pitted_in;
   logic [TIME_W-1:0]          rsp_time_ff, rsp_time_in;
   logic signed [2:0]          rsp_from_ff, rsp_from_in;
   logic [SECTOR_W-1:0]        rsp_to_ff, rsp_to_in;
   logic                       rsp_line_ff, rsp_line_in;
   logic                       rsp_pitted_ff, rsp_pitted_in;

   // Evaluation step signals
   logic [COUNT_W-1:0]         used_count;
   logic [SECTOR_W-1:0]        last_sector;
   logic [SECTOR_W-1:0]        sector_sel;
   logic [POS_W-1:0]           mark;
   logic signed [PREV_W-1:0]   pos_ext;
   logic signed [PREV_W-1:0]   prev;
   logic signed [PREV_W-1:0]   span;
   logic signed [NUM_W-1:0]    num;
   logic [DEN_W-1:0]           num_mag;
   logic signed [DELTA_W-1:0]  delta;
   logic                       sector_changed;
   logic                       crossed;
   logic                       pit_set;
   logic                       pitted_now;

   // Divider, multiplier and summing signals
   logic [DEN_W:0]             trial;
   logic                       trial_ge;
   logic [QUO_LO_W-1:0]        mul_b;
   logic [MUL_W-1:0]           mul_p;
   logic [MAGSUM_W-1:0]        mag_sum;
   logic signed [SUM_W-1:0]    base_sh;
   logic signed [SUM_W-1:0]    mag_ext;
   logic signed [SUM_W-1:0]    t_sum;

   logic                       req_fire;
   logic                       out_free;

   assign req_ready         = (state_ff == ST_IDLE) && !reset;
   assign req_fire          = req_valid && req_ready;
   assign out_free          = !rsp_valid_ff || rsp_ready;
   assign csr_ready         = !reset;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_crossing_time = rsp_time_ff;
   assign rsp_from_sector   = rsp_from_ff;
   assign rsp_to_sector     = rsp_to_ff;
   assign rsp_crossed_line  = rsp_line_ff;
   assign rsp_lap_pitted    = rsp_pitted_ff;

   // Clamp the sector count and locate the sector of the held position
   always_comb begin
      if (sector_count_ff == '0) begin
         used_count = COUNT_W'(1);
      end else if (sector_count_ff > COUNT_W'(MAX_SECTORS)) begin
         used_count = COUNT_W'(MAX_SECTORS);
      end else begin
         used_count = sector_count_ff;
      end
      last_sector = SECTOR_W'(used_count - COUNT_W'(1));
      sector_sel  = last_sector;
      for (int i = MAX_SECTORS - 1; i >= 1; i--) begin
         if (COUNT_W'(i) < used_count && pos_ff < boundary_ff[i]) begin
            sector_sel = SECTOR_W'(i - 1);
         end
      end
      mark           = boundary_ff[sector_sel];
      sector_changed = ($signed({1'b0, sector_sel}) != cur_sector_ff);
      crossed        = (sector_sel == '0) &&
                       (cur_sector_ff == $signed({1'b0, last_sector}));
   end

   // Interpolation operands: unwrap the previous position, form numerator, span and tick delta
   always_comb begin
      pos_ext = $signed({2'b00, pos_ff});
      if (last_pos_ff > pos_ext) begin
         prev = last_pos_ff - $signed(PREV_W'(ONE_FX));
      end else begin
         prev = last_pos_ff;
      end
      num     = $signed({3'b000, mark}) - $signed({prev[PREV_W-1], prev});
      span    = pos_ext - prev;
      num_mag = num[NUM_W-1] ? DEN_W'(-num) : num[DEN_W-1:0];
      delta   = $signed({2'b00, tick_ff}) - $signed({last_tick_ff[TICK_W], last_tick_ff});
   end

   // Pit flag update for the held surface code
   always_comb begin
      pit_set    = ((surface_ff == SURF_PIT_STALL) || (surface_ff == SURF_PIT_APPROACH)) &&
                   !suppress_ff;
      pitted_now = pitted_ff || pit_set;
   end

   // Restoring divide step, shared multiplier and final sum
   always_comb begin
      trial    = {rem_ff, qd_ff[QUO_W-1]};
      trial_ge = (trial >= {1'b0, den_ff});
      if (state_ff == ST_MUL_LO) begin
         mul_b = qd_ff[QUO_LO_W-1:0];
      end else begin
         mul_b = QUO_LO_W'(qd_ff[QUO_W-1:QUO_LO_W]);
      end
      mul_p   = MUL_W'(dmag_ff) * MUL_W'(mul_b);
      mag_sum = MAGSUM_W'(plo_ff) + (MAGSUM_W'(phi_ff) << QUO_LO_W);
      base_sh = $signed(SUM_W'(base_ff)) <<< FRACTION_BITS;
      mag_ext = $signed({2'b00, mag_ff});
      t_sum   = neg_ff ? (base_sh - mag_ext) : (base_sh + mag_ext);
   end

   // Sequencer and next-state logic
   always_comb begin
      state_in        = state_ff;
      sector_count_in = sector_count_ff;
      boundary_in     = boundary_ff;
      cur_sector_in   = cur_sector_ff;
      last_pos_in     = last_pos_ff;
      last_tick_in    = last_tick_ff;
      pitted_in       = pitted_ff;
      suppress_in     = suppress_ff;
      rsp_valid_in    = rsp_valid_ff;
      tick_in         = tick_ff;
      pos_in          = pos_ff;
      surface_in      = surface_ff;
      dmag_in         = dmag_ff;
      base_in         = base_ff;
      neg_in          = neg_ff;
      rem_in          = rem_ff;
      qd_in           = qd_ff;
      den_in          = den_ff;
      div_cnt_in      = div_cnt_ff;
      plo_in          = plo_ff;
      phi_in          = phi_ff;
      mag_in          = mag_ff;
      time_in         = time_ff;
      new_sector_in   = new_sector_ff;
      old_sector_in   = old_sector_ff;
      line_in         = line_ff;
      lap_pitted_in   = lap_pitted_ff;
      rsp_time_in     = rsp_time_ff;
      rsp_from_in     = rsp_from_ff;
      rsp_to_in       = rsp_to_ff;
      rsp_line_in     = rsp_line_ff;
      rsp_pitted_in   = rsp_pitted_ff;

      // Drop the result transaction once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Write configuration registers; unknown indexes are ignored
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SECTOR_COUNT: sector_count_in = COUNT_W'(csr_data);
            CSR_BOUNDARY_0:   boundary_in[0]  = csr_data;
            CSR_BOUNDARY_1:   boundary_in[1]  = csr_data;
            CSR_BOUNDARY_2:   boundary_in[2]  = csr_data;
            CSR_BOUNDARY_3:   boundary_in[3]  = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tick_in    = req_tick;
               pos_in     = req_lap_position;
               surface_in = req_surface;
               state_in   = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (surface_ff == SURF_NOT_IN_WORLD) begin
               pitted_in   = 1'b1;
               suppress_in = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               if (pit_set) begin
                  suppress_in = 1'b1;
               end else if (surface_ff == SURF_ON_TRACK) begin
                  suppress_in = 1'b0;
               end
               pitted_in    = pitted_now;
               last_pos_in  = pos_ext;
               last_tick_in = $signed({1'b0, tick_ff});
               state_in     = ST_IDLE;
               if (sector_changed) begin
                  // Capture the crossing and start the interpolation
                  new_sector_in = sector_sel;
                  old_sector_in = cur_sector_ff;
                  line_in       = crossed;
                  lap_pitted_in = crossed && pitted_now;
                  if (crossed) begin
                     pitted_in = 1'b0;
                  end
                  cur_sector_in = $signed({1'b0, sector_sel});
                  dmag_in       = delta[DELTA_W-1] ? DMAG_W'(-delta) : delta[DMAG_W-1:0];
                  base_in       = last_tick_ff;
                  neg_in        = delta[DELTA_W-1] ^ num[NUM_W-1];
                  den_in        = span[DEN_W-1:0];
                  rem_in        = '0;
                  div_cnt_in    = '0;
                  if (span == '0) begin
                     qd_in    = '0;
                     state_in = ST_MUL_LO;
                  end else begin
                     qd_in    = {num_mag, FRACTION_BITS'(0)};
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end

         ST_DIVIDE: begin
            // Shift in one quotient bit per cycle
            rem_in     = trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            qd_in      = {qd_ff[QUO_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
               state_in = ST_MUL_LO;
            end
         end

         ST_MUL_LO: begin
            plo_in   = mul_p;
            state_in = ST_MUL_HI;
         end

         ST_MUL_HI: begin
            phi_in   = mul_p;
            state_in = ST_SAT;
         end

         ST_SAT: begin
            // Saturate the product magnitude
            if (mag_sum > MAGSUM_W'(PROD_LIMIT)) begin
               mag_in = PROD_LIMIT;
            end else begin
               mag_in = mag_sum[MAG_W-1:0];
            end
            state_in = ST_SUM;
         end

         ST_SUM: begin
            // Clamp the sum, then hand it to the output register when free
            if (t_sum[SUM_W-1]) begin
               time_in = '0;
            end else if (t_sum[SUM_W-2:TIME_W] != '0) begin
               time_in = '1;
            end else begin
               time_in = t_sum[TIME_W-1:0];
            end
            if (out_free) begin
               rsp_time_in   = time_in;
               rsp_from_in   = old_sector_ff;
               rsp_to_in     = new_sector_ff;
               rsp_line_in   = line_ff;
               rsp_pitted_in = lap_pitted_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sector_count_ff <= COUNT_W'(1);
         boundary_ff[0]  <= '0;
         for (int i = 1; i < MAX_SECTORS; i++) begin
            boundary_ff[i] <= '1;
         end
         cur_sector_ff   <= -3'sd1;
         last_pos_ff     <= -$signed(PREV_W'(ONE_FX));
         last_tick_ff    <= '1;
         pitted_ff       <= 1'b0;
         suppress_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sector_count_ff <= sector_count_in;
         boundary_ff     <= boundary_in;
         cur_sector_ff   <= cur_sector_in;
         last_pos_ff     <= last_pos_in;
         last_tick_ff    <= last_tick_in;
         pitted_ff       <= pitted_in;
         suppress_ff     <= suppress_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      tick_ff       <= tick_in;
      pos_ff        <= pos_in;
      surface_ff    <= surface_in;
      dmag_ff       <= dmag_in;
      base_ff       <= base_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      qd_ff         <= qd_in;
      den_ff        <= den_in;
      div_cnt_ff    <= div_cnt_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      mag_ff        <= mag_in;
      time_ff       <= time_in;
      new_sector_ff <= new_sector_in;
      old_sector_ff <= old_sector_in;
      line_ff       <= line_in;
      lap_pitted_ff <= lap_pitted_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_pitted_ff <= rsp_pitted_in;
   end

`ifndef SYNTH
   // An accepted transaction is evaluated in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EVAL)
      else $error("accepted item not evaluated next cycle");

   // A zero divisor bypasses the divider with a zero quotient
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_LO && den_ff == '0) |-> qd_ff == '0)
      else $error("zero divisor produced nonzero quotient");

   // The saturated magnitude never exceeds the product limit
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> mag_ff <= PROD_LIMIT)
      else $error("product magnitude above limit");

   // A result appears only out of the summing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SUM))
      else $error("result raised outside summing step");

   // A line crossing always enters sector zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_line_ff) |-> rsp_to_ff == '0)
      else $error("line crossing into nonzero sector");
`endif

endmodule

`default_nettype wire
